/* hdl/svsu_pkg.sv */
// shared types, request kinds and result codes for the sorted variant set
package svsu_pkg;

   localparam int POS_W  = 31;
   localparam int BASE_W = 4;
   localparam int IDX_W  = 8;
   localparam int ACT_W  = 3;
   localparam int KIND_W = 3;
   localparam int RSP_COUNT_W = 9;

   localparam logic [1:0] REQ_ADD   = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic [ACT_W-1:0] ACT_INSERTED = 3'd0;
   localparam logic [ACT_W-1:0] ACT_UPDATED  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_REMOVED  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_DROPPED  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_READ_OK  = 3'd4;
   localparam logic [ACT_W-1:0] ACT_CLEARED  = 3'd5;
   localparam logic [ACT_W-1:0] ACT_READ_OOR = 3'd6;

   localparam logic [KIND_W-1:0] KIND_NONE   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CARRY  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SHIFT  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_DONE   = 3'd5;

   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic [BASE_W-1:0] par;
      logic [BASE_W-1:0] nb;
   } entry_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ACT_W-1:0]  act;
      entry_type         ent;
      logic [IDX_W-1:0]  idx;
   } token_type;

   function automatic token_type done_tok(input logic [ACT_W-1:0] act, input entry_type ent);
      token_type t;
      t.kind = KIND_DONE;
      t.act  = act;
      t.ent  = ent;
      t.idx  = '0;
      return t;
   endfunction

endpackage

/* hdl/svsu_cell.sv */
// one cell of the sorted chain: holds one entry and works on the passing request token
module svsu_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CNT_W-1:0]      count,
   input  logic                  full,
   input  svsu_pkg::token_type   prev_tok,
   input  svsu_pkg::entry_type   nbr_entry,
   output svsu_pkg::token_type   next_tok,
   output svsu_pkg::entry_type   entry
);

   localparam logic [CNT_W-1:0] MY_IDX   = CNT_W'(INDEX);
   localparam logic [CNT_W-1:0] NEXT_IDX = CNT_W'(INDEX + 1);

   svsu_pkg::entry_type entry_ff, entry_in;
   svsu_pkg::token_type tok_ff, tok_in;
   logic occ, occ_next;

   assign occ      = MY_IDX < count;
   assign occ_next = NEXT_IDX < count;

   always_comb begin
      entry_in = entry_ff;
      tok_in   = prev_tok;
      unique case (prev_tok.kind)
         svsu_pkg::KIND_NONE, svsu_pkg::KIND_DONE: begin
         end
         svsu_pkg::KIND_SEARCH: begin
            priority if (occ && (entry_ff.pos < prev_tok.ent.pos)) begin
               // last entry of a full store is still below: no room at the end
               if (full && !occ_next) begin
                  tok_in = svsu_pkg::done_tok(svsu_pkg::ACT_DROPPED, '0);
               end
            end else if (occ && (entry_ff.pos == prev_tok.ent.pos)) begin
               if (entry_ff.par != prev_tok.ent.nb) begin
                  entry_in.nb = prev_tok.ent.nb;
                  tok_in = svsu_pkg::done_tok(svsu_pkg::ACT_UPDATED, '0);
               end else begin
                  // reversal: close the gap from the right
                  entry_in = nbr_entry;
                  tok_in = svsu_pkg::done_tok(svsu_pkg::ACT_REMOVED, '0);
                  if (occ_next) begin
                     tok_in.kind = svsu_pkg::KIND_SHIFT;
                  end
               end
            end else if (full) begin
               tok_in = svsu_pkg::done_tok(svsu_pkg::ACT_DROPPED, '0);
            end else begin
               entry_in = prev_tok.ent;
               if (occ) begin
                  tok_in.kind = svsu_pkg::KIND_CARRY;
                  tok_in.act  = svsu_pkg::ACT_INSERTED;
                  tok_in.ent  = entry_ff;
               end else begin
                  tok_in = svsu_pkg::done_tok(svsu_pkg::ACT_INSERTED, '0);
               end
            end
         end
         svsu_pkg::KIND_CARRY: begin
            entry_in = prev_tok.ent;
            if (occ) begin
               tok_in.ent = entry_ff;
            end else begin
               tok_in = svsu_pkg::done_tok(svsu_pkg::ACT_INSERTED, '0);
            end
         end
         svsu_pkg::KIND_SHIFT: begin
            entry_in = nbr_entry;
            if (!occ_next) begin
               tok_in = svsu_pkg::done_tok(svsu_pkg::ACT_REMOVED, '0);
            end
         end
         svsu_pkg::KIND_READ: begin
            if (prev_tok.idx == '0) begin
               tok_in = svsu_pkg::done_tok(svsu_pkg::ACT_READ_OK, entry_ff);
            end else begin
               tok_in.idx = prev_tok.idx - 1'b1;
            end
         end
         default: begin
            tok_in.kind = svsu_pkg::KIND_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.kind <= svsu_pkg::KIND_NONE;
      end else begin
         tok_ff.kind <= tok_in.kind;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff.act <= tok_in.act;
      tok_ff.ent <= tok_in.ent;
      tok_ff.idx <= tok_in.idx;
      entry_ff   <= entry_in;
   end

   assign next_tok = tok_ff;
   assign entry    = entry_ff;

endmodule

/* hdl/sorted_variant_set_update.sv */
// top level of the sorted variant set: request entry, cell chain and result register
// a request token runs from the head register through every cell of the chain to the result register
// one request at a time: start is taken only while busy is low; busy drops in the strobe cycle
// the receiver cannot stall, the strobe lasts one cycle
// reset clears the entry count and all tokens in flight; stored entries are left as they are
module sorted_variant_set_update #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_type,
   input  logic [svsu_pkg::POS_W-1:0]       req_position,
   input  logic [svsu_pkg::BASE_W-1:0]      req_parent_base,
   input  logic [svsu_pkg::BASE_W-1:0]      req_new_base,
   input  logic [svsu_pkg::IDX_W-1:0]       req_read_index,
   output logic                             rsp_strobe,
   output logic [svsu_pkg::ACT_W-1:0]       rsp_action,
   output logic [svsu_pkg::RSP_COUNT_W-1:0] rsp_entry_count,
   output logic [svsu_pkg::POS_W-1:0]       rsp_read_position,
   output logic [svsu_pkg::BASE_W-1:0]      rsp_read_parent_base,
   output logic [svsu_pkg::BASE_W-1:0]      rsp_read_new_base
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > svsu_pkg::IDX_W) ? CNT_W : svsu_pkg::IDX_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

   svsu_pkg::token_type tok [0:MAX_ENTRIES];
   svsu_pkg::entry_type ent [0:MAX_ENTRIES];

   svsu_pkg::token_type head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic busy_ff, busy_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   logic [svsu_pkg::ACT_W-1:0] rsp_action_ff;
   logic [svsu_pkg::RSP_COUNT_W-1:0] rsp_count_ff;
   svsu_pkg::entry_type rsp_ent_ff;
   logic accept, full, tail_done;
   svsu_pkg::token_type tail;

   assign accept = start && !busy_ff;
   assign full   = count_ff == MAX_CNT;
   assign tail   = tok[MAX_ENTRIES];
   assign tail_done = tail.kind == svsu_pkg::KIND_DONE;

   assign tok[0] = head_ff;
   assign ent[MAX_ENTRIES] = '0;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      svsu_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .count     (count_ff),
         .full      (full),
         .prev_tok  (tok[i]),
         .nbr_entry (ent[i+1]),
         .next_tok  (tok[i+1]),
         .entry     (ent[i])
      );
   end

   // request token built from the request
   always_comb begin
      head_in.kind    = svsu_pkg::KIND_NONE;
      head_in.act     = '0;
      head_in.ent.pos = req_position;
      head_in.ent.par = req_parent_base;
      head_in.ent.nb  = req_new_base;
      head_in.idx     = req_read_index;
      if (accept) begin
         unique case (req_type)
            svsu_pkg::REQ_ADD: begin
               head_in.kind = svsu_pkg::KIND_SEARCH;
            end
            svsu_pkg::REQ_READ: begin
               if (CMP_W'(req_read_index) < CMP_W'(count_ff)) begin
                  head_in.kind = svsu_pkg::KIND_READ;
               end else begin
                  head_in = svsu_pkg::done_tok(svsu_pkg::ACT_READ_OOR, '0);
               end
            end
            svsu_pkg::REQ_CLEAR: begin
               head_in = svsu_pkg::done_tok(svsu_pkg::ACT_CLEARED, '0);
            end
            default: begin
               head_in = svsu_pkg::done_tok(svsu_pkg::ACT_READ_OOR, '0);
            end
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      if (tail_done) begin
         unique case (tail.act)
            svsu_pkg::ACT_INSERTED: count_in = count_ff + 1'b1;
            svsu_pkg::ACT_REMOVED:  count_in = count_ff - 1'b1;
            svsu_pkg::ACT_CLEARED:  count_in = '0;
            default:                count_in = count_ff;
         endcase
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (tail_done) begin
         busy_in = 1'b0;
      end
   end

   assign rsp_strobe_in = tail_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.kind  <= svsu_pkg::KIND_NONE;
         count_ff      <= '0;
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         head_ff.kind  <= head_in.kind;
         count_ff      <= count_in;
         busy_ff       <= busy_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff.act   <= head_in.act;
      head_ff.ent   <= head_in.ent;
      head_ff.idx   <= head_in.idx;
      rsp_action_ff <= tail.act;
      rsp_count_ff  <= svsu_pkg::RSP_COUNT_W'(count_in);
      rsp_ent_ff    <= tail.ent;
   end

   assign busy                 = busy_ff;
   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_action           = rsp_action_ff;
   assign rsp_entry_count      = rsp_count_ff;
   assign rsp_read_position    = rsp_ent_ff.pos;
   assign rsp_read_parent_base = rsp_ent_ff.par;
   assign rsp_read_new_base    = rsp_ent_ff.nb;

endmodule

/* sim/sorted_variant_set_update_test.sv */
// testbench for the sorted variant set: directed and random requests checked against a predictor
`timescale 1ns / 100ps

module sorted_variant_set_update_test;

   localparam int STORE_DEPTH = 256;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [svsu_pkg::ACT_W-1:0]       act;
      logic [svsu_pkg::RSP_COUNT_W-1:0] cnt;
      logic [svsu_pkg::POS_W-1:0]       pos;
      logic [svsu_pkg::BASE_W-1:0]      par;
      logic [svsu_pkg::BASE_W-1:0]      nb;
   } outcome_type;

   class variant_store_type;
      svsu_pkg::entry_type store [STORE_DEPTH];
      int unsigned         count;
      outcome_type         pending_outcomes [$];
      bit                  failed;

      function svsu_pkg::entry_type pick_entry();
         return store[$urandom_range(count - 1)];
      endfunction

      function void apply_request(logic [1:0] kind, logic [svsu_pkg::POS_W-1:0] pos,
                                  logic [svsu_pkg::BASE_W-1:0] par,
                                  logic [svsu_pkg::BASE_W-1:0] nb,
                                  logic [svsu_pkg::IDX_W-1:0] idx);
         outcome_type o;
         int unsigned k;
         o = '0;
         case (kind)
            svsu_pkg::REQ_ADD: begin
               k = 0;
               while (k < count && store[k].pos < pos) k++;
               if (k < count && store[k].pos == pos) begin
                  if (store[k].par != nb) begin
                     store[k].nb = nb;
                     o.act = svsu_pkg::ACT_UPDATED;
                  end else begin
                     for (int j = k; j + 1 < count; j++) store[j] = store[j + 1];
                     count--;
                     o.act = svsu_pkg::ACT_REMOVED;
                  end
               end else if (count >= STORE_DEPTH) begin
                  o.act = svsu_pkg::ACT_DROPPED;
               end else begin
                  for (int j = count; j > k; j--) store[j] = store[j - 1];
                  store[k].pos = pos;
                  store[k].par = par;
                  store[k].nb  = nb;
                  count++;
                  o.act = svsu_pkg::ACT_INSERTED;
               end
            end
            svsu_pkg::REQ_READ: begin
               if (idx < count) begin
                  o.act = svsu_pkg::ACT_READ_OK;
                  o.pos = store[idx].pos;
                  o.par = store[idx].par;
                  o.nb  = store[idx].nb;
               end else begin
                  o.act = svsu_pkg::ACT_READ_OOR;
               end
            end
            svsu_pkg::REQ_CLEAR: begin
               count = 0;
               o.act = svsu_pkg::ACT_CLEARED;
            end
            default: begin
               o.act = svsu_pkg::ACT_READ_OOR;
            end
         endcase
         o.cnt = svsu_pkg::RSP_COUNT_W'(count);
         pending_outcomes = {pending_outcomes, o};
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            failed = 1;
         end
      endfunction

      function void check_outcome(outcome_type got);
         outcome_type want;
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0h", $time, got);
            failed = 1;
         end else begin
            want = pending_outcomes.pop_front();
            compare_field("action", want.act, got.act);
            compare_field("entry_count", want.cnt, got.cnt);
            compare_field("read_position", want.pos, got.pos);
            compare_field("read_parent_base", want.par, got.par);
            compare_field("read_new_base", want.nb, got.nb);
         end
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   logic [1:0]                       req_type = '0;
   logic [svsu_pkg::POS_W-1:0]       req_position = '0;
   logic [svsu_pkg::BASE_W-1:0]      req_parent_base = '0;
   logic [svsu_pkg::BASE_W-1:0]      req_new_base = '0;
   logic [svsu_pkg::IDX_W-1:0]       req_read_index = '0;
   logic                             rsp_strobe;
   logic [svsu_pkg::ACT_W-1:0]       rsp_action;
   logic [svsu_pkg::RSP_COUNT_W-1:0] rsp_entry_count;
   logic [svsu_pkg::POS_W-1:0]       rsp_read_position;
   logic [svsu_pkg::BASE_W-1:0]      rsp_read_parent_base;
   logic [svsu_pkg::BASE_W-1:0]      rsp_read_new_base;

   variant_store_type sb = new();
   bit idle_on;

   sorted_variant_set_update #(.MAX_ENTRIES(STORE_DEPTH)) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_position(req_position),
      .req_parent_base(req_parent_base),
      .req_new_base(req_new_base),
      .req_read_index(req_read_index),
      .rsp_strobe(rsp_strobe),
      .rsp_action(rsp_action),
      .rsp_entry_count(rsp_entry_count),
      .rsp_read_position(rsp_read_position),
      .rsp_read_parent_base(rsp_read_parent_base),
      .rsp_read_new_base(rsp_read_new_base)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_outcome(outcome_type'{rsp_action, rsp_entry_count, rsp_read_position,
                                        rsp_read_parent_base, rsp_read_new_base});
   end

   task automatic send_request(input logic [1:0] kind,
                               input logic [svsu_pkg::POS_W-1:0] pos,
                               input logic [svsu_pkg::BASE_W-1:0] par,
                               input logic [svsu_pkg::BASE_W-1:0] nb,
                               input logic [svsu_pkg::IDX_W-1:0] idx);
      start           <= 1'b1;
      req_type        <= kind;
      req_position    <= pos;
      req_parent_base <= par;
      req_new_base    <= nb;
      req_read_index  <= idx;
      do @(posedge clock); while (busy);
      sb.apply_request(kind, pos, par, nb, idx);
   endtask

   task automatic maybe_idle(input bit allowed);
      int unsigned n;
      if (allowed && $urandom_range(3) == 0) begin
         n = $urandom_range(4, 1);
         start           <= 1'b0;
         req_type        <= 2'($urandom);
         req_position    <= svsu_pkg::POS_W'($urandom);
         req_parent_base <= svsu_pkg::BASE_W'($urandom);
         req_new_base    <= svsu_pkg::BASE_W'($urandom);
         req_read_index  <= svsu_pkg::IDX_W'($urandom);
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic random_request(input bit allow_clear);
      int unsigned roll;
      logic [1:0] kind;
      logic [svsu_pkg::POS_W-1:0] pos;
      logic [svsu_pkg::BASE_W-1:0] par, nb;
      logic [svsu_pkg::IDX_W-1:0] idx;
      svsu_pkg::entry_type e;
      roll = $urandom_range(99);
      pos = svsu_pkg::POS_W'($urandom);
      par = svsu_pkg::BASE_W'($urandom);
      nb  = svsu_pkg::BASE_W'($urandom);
      idx = svsu_pkg::IDX_W'($urandom);
      if (roll < 55) begin
         kind = svsu_pkg::REQ_ADD;
         if (sb.count != 0 && roll < 30) begin
            e = sb.pick_entry();
            pos = e.pos;
            if (roll < 15) nb = e.par;
         end else if (roll < 42) begin
            pos = svsu_pkg::POS_W'($urandom_range(63));
         end
      end else if (roll < 90) begin
         kind = svsu_pkg::REQ_READ;
         if (sb.count != 0 && roll < 78) idx = svsu_pkg::IDX_W'($urandom_range(sb.count - 1));
      end else if (roll < 94) begin
         kind = allow_clear ? svsu_pkg::REQ_CLEAR : svsu_pkg::REQ_READ;
      end else begin
         kind = REQ_UNKNOWN;
      end
      send_request(kind, pos, par, nb, idx);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(svsu_pkg::REQ_CLEAR, '0, '0, '0, '0);
      send_request(svsu_pkg::REQ_READ, '0, '0, '0, 8'd0);
      send_request(REQ_UNKNOWN, '0, '0, '0, '0);
      send_request(svsu_pkg::REQ_ADD, 31'h7FFF_FFFF, 4'hF, 4'h0, '0);
      maybe_idle(1'b1);
      send_request(svsu_pkg::REQ_ADD, 31'h0, 4'h0, 4'hF, '0);
      send_request(svsu_pkg::REQ_ADD, 31'h2AAA_AAAA, 4'h1, 4'h2, '0);
      send_request(svsu_pkg::REQ_ADD, 31'h5555_5555, 4'h4, 4'h8, '0);
      send_request(svsu_pkg::REQ_ADD, 31'h2AAA_AAAA, 4'h9, 4'h4, '0);
      send_request(svsu_pkg::REQ_READ, '0, '0, '0, 8'd1);
      send_request(svsu_pkg::REQ_READ, '0, '0, '0, 8'd0);
      maybe_idle(1'b1);
      send_request(svsu_pkg::REQ_READ, '0, '0, '0, 8'd3);
      send_request(svsu_pkg::REQ_READ, '0, '0, '0, 8'd4);
      send_request(svsu_pkg::REQ_READ, '0, '0, '0, 8'd255);
      send_request(svsu_pkg::REQ_ADD, 31'h5555_5555, 4'hF, 4'h4, '0);
      send_request(svsu_pkg::REQ_ADD, 31'h0, 4'hF, 4'h0, '0);
      send_request(svsu_pkg::REQ_ADD, 31'h7FFF_FFFF, 4'h0, 4'h8, '0);
      send_request(REQ_UNKNOWN, '1, '1, '1, '1);
      send_request(svsu_pkg::REQ_READ, '0, '0, '0, 8'd1);
      send_request(svsu_pkg::REQ_CLEAR, '1, '1, '1, '1);
      send_request(svsu_pkg::REQ_READ, '0, '0, '0, 8'd0);
      send_request(svsu_pkg::REQ_ADD, 31'd5, 4'h2, 4'h2, '1);
      send_request(svsu_pkg::REQ_ADD, 31'd5, 4'h8, 4'h2, '1);

      for (int i = 0; i < 350; i++) begin
         if (i % 50 == 0) idle_on = 1'($urandom_range(1));
         maybe_idle(idle_on);
         random_request(1'b1);
      end

      // fill the store, then work on it from full, with no clear requests
      while (sb.count < STORE_DEPTH) begin
         maybe_idle(idle_on);
         send_request(svsu_pkg::REQ_ADD, svsu_pkg::POS_W'($urandom),
                      svsu_pkg::BASE_W'($urandom), svsu_pkg::BASE_W'($urandom),
                      svsu_pkg::IDX_W'($urandom));
      end
      send_request(svsu_pkg::REQ_READ, '0, '0, '0, 8'd255);
      for (int i = 0; i < 40; i++) begin
         maybe_idle(1'b1);
         random_request(1'b0);
      end
      send_request(svsu_pkg::REQ_CLEAR, svsu_pkg::POS_W'($urandom),
                   svsu_pkg::BASE_W'($urandom), svsu_pkg::BASE_W'($urandom),
                   svsu_pkg::IDX_W'($urandom));

      for (int i = 0; i < 250; i++) begin
         if (i % 50 == 0) idle_on = 1'($urandom_range(1));
         maybe_idle(idle_on);
         random_request(1'b1);
      end
      for (int i = 0; i < 100; i++) random_request(1'b1);
      start <= 1'b0;

      while (sb.pending_outcomes.size() != 0) @(posedge clock);
      repeat (STORE_DEPTH + 4) @(posedge clock);
      if (!sb.failed && sb.pending_outcomes.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #15_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

/* sim.f */
hdl/svsu_pkg.sv
hdl/svsu_cell.sv
hdl/sorted_variant_set_update.sv
sim/sorted_variant_set_update_test.sv
